// File: rtl/sbb_pkg.sv
// ----------------------------------------------------------------------------
// sbb_pkg
// Shared constants, types and arithmetic for the separable 3x3 box blur.
// ----------------------------------------------------------------------------
package sbb_pkg;

  localparam int MAX_WIDTH = 2048;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int WID_W     = 12;
  localparam int HGT_W     = 16;
  localparam int PIX_W     = 8;
  localparam int SUM_W     = 10;
  localparam int CFG_W     = 16;

  localparam logic [WID_W-1:0] MIN_WIDTH  = WID_W'(3);
  localparam logic [WID_W-1:0] WIDTH_CAP  = WID_W'(MAX_WIDTH);
  localparam logic [HGT_W-1:0] MIN_HEIGHT = HGT_W'(3);
  localparam logic [WID_W-1:0] RST_WIDTH  = WID_W'(640);
  localparam logic [HGT_W-1:0] RST_HEIGHT = HGT_W'(480);

  // reciprocal of 3, exact for sums below 2048
  localparam int RECIP3 = 683;
  localparam int RSHIFT = 11;

  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  function automatic logic [PIX_W-1:0] div3(input logic [SUM_W-1:0] x);
    logic [SUM_W+RSHIFT-1:0] prod;
    prod = (SUM_W+RSHIFT)'(x) * (SUM_W+RSHIFT)'(RECIP3);
    return prod[RSHIFT +: PIX_W];
  endfunction

endpackage

// File: rtl/separable_box_blur_3x3.sv
// Pipeline: a result is registered in stage 1, then in the output register.
// Throughput: one pixel per cycle unless a full output stage waits on out_ready;
// both line stores are read, only the selected one is written, read-before-write on the same column.
// Reset: synchronous, active low; clears counters, pixel history, store
// select and pipeline valids. Line stores are not cleared.
// ----------------------------------------------------------------------------
// separable_box_blur_3x3
// Streaming 3x3 box blur: horizontal thirds kept in two line stores, summed
// vertically with the current row and divided by three.
// ----------------------------------------------------------------------------
module separable_box_blur_3x3
  import sbb_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [PIX_W-1:0] in_pixel_value,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [PIX_W-1:0] out_blurred_value,
  output logic             out_frame_last,
  input  logic             cfg_we,
  input  cfg_reg_t         cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  logic [WID_W-1:0] width_r;
  logic [HGT_W-1:0] height_r;
  logic [WID_W-1:0] eff_w;
  logic [HGT_W-1:0] eff_h;

  logic [PIX_W-1:0] prev1_r, prev2_r;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [HGT_W-1:0] row_r, row_nxt;
  logic             sel_r, sel_nxt;

  logic [PIX_W-1:0] mem_a [MAX_WIDTH];
  logic [PIX_W-1:0] mem_b [MAX_WIDTH];
  logic [PIX_W-1:0] rd_a_r, rd_b_r;

  logic             s1_valid_r;
  logic             s1_emit_r;
  logic             s1_last_r;
  logic [PIX_W-1:0] s1_hval_r;

  logic             out_valid_r;
  logic [PIX_W-1:0] out_value_r;
  logic             out_last_r;

  logic             accept;
  logic             advance;
  logic             last_col;
  logic             last_row;
  logic             has_triple;
  logic             emit;
  logic [PIX_W-1:0] hval;
  logic [SUM_W-1:0] vsum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_WIDTH;
      height_r <= RST_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  width_r  <= cfg_data[WID_W-1:0];
        REG_IMAGE_HEIGHT: height_r <= cfg_data[HGT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    eff_w = width_r;
    if (width_r < MIN_WIDTH) eff_w = MIN_WIDTH;
    if (width_r > WIDTH_CAP) eff_w = WIDTH_CAP;
    eff_h = (height_r < MIN_HEIGHT) ? MIN_HEIGHT : height_r;
  end

  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || advance;
  assign accept   = in_valid && in_ready;

  assign last_col   = ({1'b0, col_r} + 12'd1) >= eff_w;
  assign last_row   = ({1'b0, row_r} + 17'd1) >= {1'b0, eff_h};
  assign has_triple = (col_r >= COL_W'(2));
  assign emit       = has_triple && (row_r >= HGT_W'(2));
  assign hval       = div3(SUM_W'(prev2_r) + SUM_W'(prev1_r) + SUM_W'(in_pixel_value));

  always_comb begin
    col_nxt = col_r + COL_W'(1);
    row_nxt = row_r;
    sel_nxt = sel_r;
    if (last_col) begin
      col_nxt = '0;
      if (last_row) begin
        row_nxt = '0;
        sel_nxt = 1'b0;
      end else begin
        row_nxt = row_r + HGT_W'(1);
        sel_nxt = !sel_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev1_r <= '0;
      prev2_r <= '0;
      col_r   <= '0;
      row_r   <= '0;
      sel_r   <= 1'b0;
    end else if (accept) begin
      prev2_r <= prev1_r;
      prev1_r <= in_pixel_value;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      sel_r   <= sel_nxt;
    end
  end

  // line store A: read old word, then write the new horizontal third when sel_r is low
  always_ff @(posedge clk) begin
    if (accept && has_triple) begin
      rd_a_r <= mem_a[col_r];
      if (!sel_r) mem_a[col_r] <= hval;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && has_triple) begin
      rd_b_r <= mem_b[col_r];
      if (sel_r) mem_b[col_r] <= hval;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_emit_r <= emit;
      s1_last_r <= last_col && last_row;
      s1_hval_r <= hval;
    end
  end

  assign vsum = SUM_W'(rd_a_r) + SUM_W'(rd_b_r) + SUM_W'(s1_hval_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r && s1_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r && s1_emit_r) begin
      out_value_r <= div3(vsum);
      out_last_r  <= s1_last_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_blurred_value = out_value_r;
  assign out_frame_last    = out_last_r;

`ifndef SYNTHESIS
  a_hold_stage1: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r && $stable(s1_hval_r) && $stable(rd_a_r))
    else $error("stage 1 word lost during stall");

  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid_r && out_valid_r && !out_ready)
    else $error("input stalled without a full pipeline");

  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    accept && last_col && last_row |=> col_r == '0 && row_r == '0 && !sel_r)
    else $error("frame end did not return position to origin");

  a_emit_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    accept && emit |=> s1_valid_r && s1_emit_r)
    else $error("interior pixel did not enter stage 1");

  a_sel_unchanged: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !last_col |=> $stable(sel_r))
    else $error("store select changed mid-row");
`endif

endmodule
